@@ src/ughs_pkg.sv @@
`default_nettype none
package ughs_pkg;

    localparam int MAX_CELLS     = 256;
    localparam int CELL_CAPACITY = 16;
    localparam int MAX_SPAN      = 2;

    localparam int CELL_W  = 8;     // cell index bits
    localparam int SLOT_W  = 4;     // slot bits within a cell
    localparam int FILL_W  = 5;     // fill count, 0..CELL_CAPACITY
    localparam int COORD_W = 16;
    localparam int IDX_W   = 27;    // signed linear cell index

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_QUERY  = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_LOOKUP = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_CELL_SIZE   = 2'd0,
        REG_GRID_WIDTH  = 2'd1,
        REG_GRID_HEIGHT = 2'd2,
        REG_NONE        = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVS,
        ST_DIV,
        ST_SPAN1,
        ST_SPAN2,
        ST_CELL,
        ST_CHK,
        ST_FILL,
        ST_QRD,
        ST_NEXT,
        ST_END
    } ughs_state_t;

    typedef struct packed {
        logic ld_in;
        logic div_start;
        logic span1;
        logic span2;
        logic cell_ld;
        logic fill_rd;
        logic add_upd;
        logic q_first;
        logic q_adv;
        logic walk_next;
        logic end_push;
    } ughs_cmd_t;

    typedef struct packed {
        func_t func;
        logic  inr;
        logic  alloc_hit;
        logic  fill_zero;
        logic  j_more;
        logic  walk_last;
        logic  out_free;
        logic  pend_blocked;
        logic  pend_v;
        logic  div_done;
    } ughs_sts_t;

    typedef struct packed {
        logic [15:0]       found_item;
        logic              hit;
        logic [CELL_W-1:0] cell_index;
        logic              found;
        logic              stored;
        logic              overflow;
        logic              last;
    } ughs_beat_t;

endpackage
`default_nettype wire

@@ src/uniform_grid_spatial_hash.sv @@
// channel | dir | beat content
// apb     | in  | cell_size @0x0, grid_width @0x4, grid_height @0x8
// s_      | in  | one request: add, query, clear or point lookup
// m_      | out | one beat per request, one per id for a query with hits
//
// A clear or lookup request skips the cell walk; add and query requests visit
// each span cell. The 16-step serial dividers for x and y run in parallel at the
// start of every request. Reset is synchronous on aresetn and empties all
// cells at once. s_tready is high only between requests; m_ back-pressure
// stalls the id walk.
`default_nettype none
module uniform_grid_spatial_hash (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // item_id[15:0] box_x[31:16] box_y[47:32] box_w[62:48] box_h[77:63] create_cell[78]
    input  wire logic [79:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // found_item[15:0] hit[16] cell_index[24:17] found[25] stored[26] overflow[27]
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);
    import ughs_pkg::*;

    logic [10:0] cell_size_reg, cell_size_next;
    logic [8:0]  grid_width_reg, grid_width_next;
    logic [8:0]  grid_height_reg, grid_height_next;
    reg_idx_t    widx;
    logic        wr_en;
    ughs_cmd_t   cmd;
    ughs_sts_t   sts;
    ughs_beat_t  beat;

    assign widx  = reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cell_size_next   = cell_size_reg;
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (wr_en) begin
            case (widx)
                REG_CELL_SIZE:   cell_size_next   = pwdata[10:0];
                REG_GRID_WIDTH:  grid_width_next  = pwdata[8:0];
                REG_GRID_HEIGHT: grid_height_next = pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_CELL_SIZE:   prdata = {21'd0, cell_size_reg};
            REG_GRID_WIDTH:  prdata = {23'd0, grid_width_reg};
            REG_GRID_HEIGHT: prdata = {23'd0, grid_height_reg};
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg   <= 11'd32;
            grid_width_reg  <= 9'd16;
            grid_height_reg <= 9'd16;
        end else begin
            cell_size_reg   <= cell_size_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    ughs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    ughs_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_func(func_t'(s_tuser)), .in_item_id(s_tdata[15:0]),
        .in_box_x(s_tdata[31:16]), .in_box_y(s_tdata[47:32]),
        .in_box_w(s_tdata[62:48]), .in_box_h(s_tdata[77:63]),
        .in_create_cell(s_tdata[78]),
        .cell_size(cell_size_reg), .grid_width(grid_width_reg),
        .grid_height(grid_height_reg),
        .out_beat(beat), .out_valid(m_tvalid), .out_ready(m_tready)
    );

    assign m_tdata = {4'd0, beat.overflow, beat.stored, beat.found, beat.cell_index,
                      beat.hit, beat.found_item};
    assign m_tlast = beat.last;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");
    a_pend_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.pend_v)
        else $error("query id left pending between requests");
    a_hit_found_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[16] && m_tdata[25]))
        else $error("hit and found set in one beat");
`endif
endmodule
`default_nettype wire

@@ src/ughs_div.sv @@
`default_nettype none
module ughs_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [10:0] divisor,
    output logic      [15:0] quo,
    output logic      [10:0] rem,
    output logic             done
);
    // restoring divider, one quotient bit per cycle
    logic [15:0] q_reg, q_next;
    logic [10:0] r_reg, r_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [11:0] t;
    logic [11:0] diff;
    logic        ge;

    always_comb begin
        t    = {r_reg, q_reg[15]};
        ge   = t >= {1'b0, divisor};
        diff = t - {1'b0, divisor};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            q_next   = {q_reg[14:0], ge};
            r_next   = ge ? diff[10:0] : t[10:0];
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign quo  = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

@@ src/ughs_dp.sv @@
`default_nettype none
module ughs_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ughs_pkg::ughs_cmd_t cmd,
    output ughs_pkg::ughs_sts_t      sts,
    input  wire ughs_pkg::func_t     in_func,
    input  wire logic [15:0]         in_item_id,
    input  wire logic [15:0]         in_box_x,
    input  wire logic [15:0]         in_box_y,
    input  wire logic [14:0]         in_box_w,
    input  wire logic [14:0]         in_box_h,
    input  wire logic                in_create_cell,
    input  wire logic [10:0]         cell_size,
    input  wire logic [8:0]          grid_width,
    input  wire logic [8:0]          grid_height,
    output ughs_pkg::ughs_beat_t     out_beat,
    output logic                     out_valid,
    input  wire logic                out_ready
);
    import ughs_pkg::*;

    func_t               func_reg;
    logic [15:0]         item_reg;
    logic signed [15:0]  x_reg, y_reg;
    logic [14:0]         w_reg, h_reg;
    logic                create_reg;

    logic [10:0]         cs;
    logic [15:0]         magx, magy, qx, qy;
    logic [10:0]         rx, ry;
    logic                donex, doney;

    logic signed [16:0]  fqx, fqy;
    logic signed [11:0]  remx, remy;
    logic signed [16:0]  vx, vy;
    logic [2:0]          spx, spy;
    logic signed [IDX_W-1:0] prod_next;
    logic [17:0]         area;
    logic [8:0]          lim_next;

    logic signed [16:0]  fqx_reg;
    logic signed [IDX_W-1:0] prod_reg, base_reg, idx;
    logic [1:0]          sx_reg, sy_reg;
    logic [8:0]          lim_reg;
    logic                ovf_reg, stored_reg;
    logic                r_reg, c_reg;
    logic                c_last, r_last;
    logic [CELL_W-1:0]   idx8_reg;
    logic                inr_reg, inr_next;
    logic                first_inr, look_found;

    logic [FILL_W-1:0]   fill_mem [MAX_CELLS];
    logic [15:0]         store_mem [MAX_CELLS*CELL_CAPACITY];
    logic [FILL_W-1:0]   fill_q_reg, fill_now;
    logic                fill_v_reg;
    logic [MAX_CELLS-1:0] alloc_reg, alloc_next;
    logic [MAX_CELLS-1:0] fill_vld_reg, fill_vld_next;
    logic [15:0]         store_q_reg;
    logic [FILL_W-1:0]   j_reg, j_plus;
    logic                add_wr, st_rd;
    logic [CELL_W+SLOT_W-1:0] st_raddr;

    logic [15:0]         pend_reg;
    logic                pend_v_reg, pend_v_next;
    ughs_beat_t          out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free, push_pend;

    function automatic logic [2:0] span_of(input logic signed [16:0] v,
                                           input logic [10:0] c);
        logic signed [16:0] c1;
        logic signed [16:0] c2;
        logic [2:0]         res;
        c1 = $signed({6'd0, c});
        c2 = $signed({5'd0, c, 1'b0});
        if (v <= 0) begin
            res = 3'b000;
        end else if (v <= c1) begin
            res = 3'b001;
        end else if (v <= c2) begin
            res = 3'b010;
        end else begin
            res = {1'b1, 2'(MAX_SPAN)};
        end
        return res;
    endfunction

    assign cs   = (cell_size == 11'd0) ? 11'd1 : cell_size;
    assign magx = x_reg[15] ? 16'(-x_reg) : 16'(x_reg);
    assign magy = y_reg[15] ? 16'(-y_reg) : 16'(y_reg);

    ughs_div u_divx (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(magx), .divisor(cs), .quo(qx), .rem(rx), .done(donex)
    );
    ughs_div u_divy (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(magy), .divisor(cs), .quo(qy), .rem(ry), .done(doney)
    );

    // floor quotient and truncated remainder from magnitude results
    always_comb begin
        fqx = !x_reg[15] ? $signed({1'b0, qx})
            : ((rx != 11'd0) ? ~$signed({1'b0, qx}) : -$signed({1'b0, qx}));
        fqy = !y_reg[15] ? $signed({1'b0, qy})
            : ((ry != 11'd0) ? ~$signed({1'b0, qy}) : -$signed({1'b0, qy}));
        remx = x_reg[15] ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
        remy = y_reg[15] ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
        vx = 17'(remx) + $signed({2'b00, w_reg});
        vy = 17'(remy) + $signed({2'b00, h_reg});
        spx = span_of(vx, cs);
        spy = span_of(vy, cs);
        prod_next = IDX_W'(fqy) * $signed({18'd0, grid_width});
        area = {9'd0, grid_width} * {9'd0, grid_height};
        lim_next = (area > 18'(MAX_CELLS)) ? 9'(MAX_CELLS) : area[8:0];
    end

    assign idx = base_reg + (r_reg ? $signed({18'd0, grid_width}) : '0)
                 + $signed({26'd0, c_reg});
    assign inr_next = (sx_reg != 2'd0) && (sy_reg != 2'd0) && !idx[IDX_W-1]
                      && (idx < $signed({18'd0, lim_reg}));
    assign first_inr = !base_reg[IDX_W-1] && (base_reg < $signed({18'd0, lim_reg}));
    assign look_found = first_inr && (alloc_reg[base_reg[CELL_W-1:0]] || create_reg);

    assign c_last = ({1'b0, c_reg} + 2'd1) >= sx_reg;
    assign r_last = ({1'b0, r_reg} + 2'd1) >= sy_reg;

    assign fill_now = fill_v_reg ? fill_q_reg : '0;
    assign j_plus   = j_reg + 5'd1;
    assign add_wr   = cmd.add_upd && (fill_now < FILL_W'(CELL_CAPACITY));
    assign st_rd    = cmd.q_first || (cmd.q_adv && (j_plus < fill_now));
    assign st_raddr = {idx8_reg, cmd.q_first ? {SLOT_W{1'b0}} : j_plus[SLOT_W-1:0]};

    // input and walk registers
    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            func_reg   <= in_func;
            item_reg   <= in_item_id;
            x_reg      <= $signed(in_box_x);
            y_reg      <= $signed(in_box_y);
            w_reg      <= in_box_w;
            h_reg      <= in_box_h;
            create_reg <= in_create_cell;
        end
        if (cmd.span1) begin
            fqx_reg    <= fqx;
            prod_reg   <= prod_next;
            sx_reg     <= spx[1:0];
            sy_reg     <= spy[1:0];
            lim_reg    <= lim_next;
            ovf_reg    <= spx[2] | spy[2];
            stored_reg <= 1'b0;
        end
        if (cmd.span2) begin
            base_reg <= IDX_W'(fqx_reg) + prod_reg;
            r_reg    <= 1'b0;
            c_reg    <= 1'b0;
        end
        if (cmd.cell_ld) begin
            idx8_reg <= idx[CELL_W-1:0];
            inr_reg  <= inr_next;
        end
        if (cmd.walk_next) begin
            if (c_last) begin
                c_reg <= 1'b0;
                r_reg <= 1'b1;
            end else begin
                c_reg <= 1'b1;
            end
        end
        if (cmd.add_upd) begin
            stored_reg <= 1'b1;
            if (!add_wr) begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.q_first) begin
            j_reg <= '0;
        end else if (cmd.q_adv) begin
            j_reg <= j_plus;
        end
        if (cmd.q_adv) begin
            pend_reg <= store_q_reg;
        end
        out_reg <= out_next;
    end

    // cell fill and item memories
    always_ff @(posedge aclk) begin
        if (cmd.fill_rd) begin
            fill_q_reg <= fill_mem[idx8_reg];
            fill_v_reg <= fill_vld_reg[idx8_reg];
        end
        if (add_wr) begin
            fill_mem[idx8_reg] <= fill_now + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (add_wr) begin
            store_mem[{idx8_reg, fill_now[SLOT_W-1:0]}] <= item_reg;
        end
        if (st_rd) begin
            store_q_reg <= store_mem[st_raddr];
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign push_pend = cmd.q_adv && pend_v_reg;

    always_comb begin
        alloc_next    = alloc_reg;
        fill_vld_next = fill_vld_reg;
        pend_v_next   = pend_v_reg;
        out_next      = out_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (cmd.add_upd) begin
            alloc_next[idx8_reg] = 1'b1;
        end
        if (add_wr) begin
            fill_vld_next[idx8_reg] = 1'b1;
        end
        if (cmd.q_adv) begin
            pend_v_next = 1'b1;
        end
        if (push_pend) begin
            out_next = '{found_item: pend_reg, hit: 1'b1, cell_index: '0, found: 1'b0,
                         stored: 1'b0, overflow: ovf_reg, last: 1'b0};
            out_valid_next = 1'b1;
        end
        if (cmd.end_push) begin
            out_valid_next = 1'b1;
            pend_v_next    = 1'b0;
            out_next = '{found_item: '0, hit: 1'b0, cell_index: '0, found: 1'b0,
                         stored: 1'b0, overflow: 1'b0, last: 1'b1};
            case (func_reg)
                FN_ADD: begin
                    out_next.stored   = stored_reg;
                    out_next.overflow = ovf_reg;
                end
                FN_QUERY: begin
                    out_next.found_item = pend_v_reg ? pend_reg : '0;
                    out_next.hit        = pend_v_reg;
                    out_next.overflow   = ovf_reg;
                end
                FN_CLEAR: begin
                    fill_vld_next = '0;
                end
                FN_LOOKUP: begin
                    if (look_found) begin
                        alloc_next[base_reg[CELL_W-1:0]] = 1'b1;
                        out_next.found      = 1'b1;
                        out_next.cell_index = base_reg[CELL_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg     <= '0;
            fill_vld_reg  <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            alloc_reg     <= alloc_next;
            fill_vld_reg  <= fill_vld_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        sts.func         = func_reg;
        sts.inr          = inr_reg;
        sts.alloc_hit    = alloc_reg[idx8_reg];
        sts.fill_zero    = (fill_now == '0);
        sts.j_more       = j_plus < fill_now;
        sts.walk_last    = c_last && r_last;
        sts.out_free     = out_free;
        sts.pend_blocked = pend_v_reg && !out_free;
        sts.pend_v       = pend_v_reg;
        sts.div_done     = donex && doney;
    end

    assign out_beat  = out_reg;
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

@@ src/ughs_ctrl.sv @@
`default_nettype none
module ughs_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ughs_pkg::ughs_sts_t sts,
    output ughs_pkg::ughs_cmd_t      cmd
);
    import ughs_pkg::*;

    ughs_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_DIVS;
            ST_DIVS:  state_next = ST_DIV;
            ST_DIV:   if (sts.div_done) state_next = ST_SPAN1;
            ST_SPAN1: state_next = ST_SPAN2;
            ST_SPAN2: begin
                if (sts.func inside {FN_CLEAR, FN_LOOKUP}) state_next = ST_END;
                else state_next = ST_CELL;
            end
            ST_CELL:  state_next = ST_CHK;
            ST_CHK: begin
                if (sts.inr && (sts.func == FN_ADD || sts.alloc_hit)) state_next = ST_FILL;
                else state_next = ST_NEXT;
            end
            ST_FILL: begin
                if (sts.func != FN_ADD && !sts.fill_zero) state_next = ST_QRD;
                else state_next = ST_NEXT;
            end
            ST_QRD:   if (!sts.pend_blocked && !sts.j_more) state_next = ST_NEXT;
            ST_NEXT: begin
                if (sts.walk_last) state_next = ST_END;
                else state_next = ST_CELL;
            end
            ST_END:   if (sts.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.ld_in  = in_valid;
            end
            ST_DIVS:  cmd.div_start = 1'b1;
            ST_DIV: begin
            end
            ST_SPAN1: cmd.span1 = 1'b1;
            ST_SPAN2: cmd.span2 = 1'b1;
            ST_CELL:  cmd.cell_ld = 1'b1;
            ST_CHK:   cmd.fill_rd = sts.inr && (sts.func == FN_ADD || sts.alloc_hit);
            ST_FILL: begin
                cmd.add_upd = (sts.func == FN_ADD);
                cmd.q_first = (sts.func != FN_ADD) && !sts.fill_zero;
            end
            ST_QRD:   cmd.q_adv = !sts.pend_blocked;
            ST_NEXT:  cmd.walk_next = !sts.walk_last;
            ST_END:   cmd.end_push = sts.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire
